@@ rtl/ea2r_pkg.sv @@
// Package of shared constants, types and arithmetic helpers for the attitude matrix block.
package ea2r_pkg;

  // Width of the CORDIC x and y datapath.
  localparam int XY_W   = 34;
  localparam int Z_W    = 36;
  localparam int PROD_W = 36;
  localparam int TBL_MAX = 32;

  // Pi and pi/2 in Q.30.
  localparam logic signed [Z_W-1:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] HALFPI_Q30 = 36'sd1686629713;

  typedef logic signed [XY_W-1:0]   xy_t;
  typedef logic signed [Z_W-1:0]    zacc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Pipeline control shared by the lanes and the merging stage.
  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

  // Arctangent of 2^-i in Q.30.
  function automatic zacc_t atan_q30(input int idx);
    zacc_t v;
    case (idx)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043837;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021687;
      5:  v = 36'sd33543516;
      6:  v = 36'sd16775851;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194283;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048576;
      default: begin
        if (idx <= 30) v = zacc_t'(64'd1 << (30 - idx));
        else v = '0;
      end
    endcase
    return v;
  endfunction

  // Square root of the squared CORDIC gain accumulated in Q.60, giving the gain in Q.30.
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] bitv;
    p = 64'd1 << 60;
    for (int i = 0; i < TBL_MAX; i++) begin
      if (i < n) p = p + (p >> (2 * i));
    end
    r = '0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (p >= r + bitv) begin
        p = p - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Q.30 product with rounding half up.
  function automatic prod_t mul30(input prod_t a, input prod_t b);
    logic signed [2*PROD_W-1:0] p;
    logic signed [2*PROD_W-1:0] q;
    p = a * b;
    q = (p + (72'sd1 <<< 29)) >>> 30;
    return q[PROD_W-1:0];
  endfunction

endpackage

@@ rtl/ea2r_in_if.sv @@
// Input channel interface carrying three attitude angles.
interface ea2r_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
  modport sink   (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

@@ rtl/ea2r_out_if.sv @@
// Result channel interface carrying the nine rotation matrix elements.
interface ea2r_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r00;
  logic signed [15:0] r01;
  logic signed [15:0] r02;
  logic signed [15:0] r10;
  logic signed [15:0] r11;
  logic signed [15:0] r12;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;

  modport source (output valid, output r00, output r01, output r02, output r10, output r11,
                  output r12, output r20, output r21, output r22, input ready);
  modport sink   (input valid, input r00, input r01, input r02, input r10, input r11,
                  input r12, input r20, input r21, input r22, output ready);
endinterface

@@ rtl/ea2r_cordic_lane.sv @@
// Pipelined rotation-mode CORDIC lane giving the sine and cosine of one angle.
module ea2r_cordic_lane
  import ea2r_pkg::*;
#(
  parameter int STAGES  = 16,
  parameter logic [63:0] START_X = 64'd0
) (
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  logic signed [15:0] angle,
  output xy_t                sin_o,
  output xy_t                cos_o
);

  xy_t   x_r   [STAGES+1];
  xy_t   y_r   [STAGES+1];
  zacc_t z_r   [STAGES+1];
  logic  neg_r [STAGES+1];

  zacc_t z_in;
  zacc_t z_nxt;
  logic  neg_nxt;

  // Scale to Q.30 and fold angles beyond a quarter turn.
  always_comb begin
    z_in    = zacc_t'(angle) <<< 17;
    z_nxt   = z_in;
    neg_nxt = 1'b0;
    if (z_in > HALFPI_Q30) begin
      z_nxt   = z_in - PI_Q30;
      neg_nxt = 1'b1;
    end else if (z_in < -HALFPI_Q30) begin
      z_nxt   = z_in + PI_Q30;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      x_r[0]   <= xy_t'(START_X);
      y_r[0]   <= '0;
      z_r[0]   <= z_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  // One micro-rotation per pipeline stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam zacc_t ATAN_I = atan_q30(i);
    xy_t dx;
    xy_t dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][Z_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end
      end
    end
  end

  // Undo the fold by negating both results.
  assign cos_o = neg_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
  assign sin_o = neg_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];

endmodule

@@ rtl/ea2r_merge.sv @@
// Merging stage forming the nine matrix elements from the lane sines and cosines.
module ea2r_merge
  import ea2r_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic              clk,
  input  pipe_ctrl_t        ctrl,
  input  xy_t               sx,
  input  xy_t               cx,
  input  xy_t               sy,
  input  xy_t               cy,
  input  xy_t               sz,
  input  xy_t               cz,
  output logic signed [15:0] r_o [9]
);

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND = prod_t'((64'd1 << SH) >> 1);
  localparam logic signed [PROD_W-1:0] LIM = prod_t'(64'd1 << OUT_FRAC_BITS);

  // Round to the output format and clamp to plus or minus one.
  function automatic logic [15:0] to_out(input prod_t v);
    prod_t w;
    w = (v + RND) >>> SH;
    if (w > LIM) w = LIM;
    if (w < -LIM) w = -LIM;
    return w[15:0];
  endfunction

  prod_t sxsy_r, sxcy_r, cxsz_r, cxcz_r, cxsy_r, cxcy_r, cycz_r, sycz_r, cysz_r, sysz_r;
  prod_t sx1_r, sz1_r, cz1_r;
  prod_t t0_r, t2_r, t3_r, t5_r;
  prod_t cxsz2_r, cxcz2_r, cxsy2_r, cxcy2_r, cycz2_r, sycz2_r, cysz2_r, sysz2_r, sx2_r;
  logic signed [15:0] r_r [9];

  // First products of pairs.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      sxsy_r <= mul30(prod_t'(sx), prod_t'(sy));
      sxcy_r <= mul30(prod_t'(sx), prod_t'(cy));
      cxsz_r <= mul30(prod_t'(cx), prod_t'(sz));
      cxcz_r <= mul30(prod_t'(cx), prod_t'(cz));
      cxsy_r <= mul30(prod_t'(cx), prod_t'(sy));
      cxcy_r <= mul30(prod_t'(cx), prod_t'(cy));
      cycz_r <= mul30(prod_t'(cy), prod_t'(cz));
      sycz_r <= mul30(prod_t'(sy), prod_t'(cz));
      cysz_r <= mul30(prod_t'(cy), prod_t'(sz));
      sysz_r <= mul30(prod_t'(sy), prod_t'(sz));
      sx1_r  <= prod_t'(sx);
      sz1_r  <= prod_t'(sz);
      cz1_r  <= prod_t'(cz);
    end
  end

  // Triple products and carried pairs.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      t0_r    <= mul30(sxsy_r, sz1_r);
      t2_r    <= mul30(sxcy_r, sz1_r);
      t3_r    <= mul30(sxsy_r, cz1_r);
      t5_r    <= mul30(sxcy_r, cz1_r);
      cxsz2_r <= cxsz_r;
      cxcz2_r <= cxcz_r;
      cxsy2_r <= cxsy_r;
      cxcy2_r <= cxcy_r;
      cycz2_r <= cycz_r;
      sycz2_r <= sycz_r;
      cysz2_r <= cysz_r;
      sysz2_r <= sysz_r;
      sx2_r   <= sx1_r;
    end
  end

  // Sums, rounding and saturation into the output register.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      r_r[0] <= to_out(t0_r + cycz2_r);
      r_r[1] <= to_out(cxsz2_r);
      r_r[2] <= to_out(t2_r - sycz2_r);
      r_r[3] <= to_out(t3_r + cysz2_r);
      r_r[4] <= to_out(cxcz2_r);
      r_r[5] <= to_out(t5_r + sysz2_r);
      r_r[6] <= to_out(cxsy2_r);
      r_r[7] <= to_out(-sx2_r);
      r_r[8] <= to_out(cxcy2_r);
    end
  end

  assign r_o = r_r;

endmodule

@@ rtl/euler_angles_to_rotation_matrix.sv @@
// Top level: attitude angles in, z-x-y rotation matrix out.
//  Channel   Dir   Payload                      Handshake
//  in_ch     in    angle_x, angle_y, angle_z    valid/ready
//  out_ch    out   r00 .. r22                   valid/ready
// One transaction is accepted per cycle while the output is not stalled;
// the CORDIC stage count is capped at 32.
// The pipeline is one input register, one stage per micro-rotation in each of
// the three CORDIC lanes, and three multiply and merge stages.
// Reset clears only the valid pipeline.
// A stall at the output holds the whole pipeline, and in_ch.ready falls with it.
module euler_angles_to_rotation_matrix
  import ea2r_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ea2r_in_if.sink    in_ch,
  ea2r_out_if.source out_ch
);

  localparam int N = (CORDIC_STAGES > TBL_MAX) ? TBL_MAX : CORDIC_STAGES;
  localparam int LAT = N + 4;
  localparam logic [63:0] GAIN_A = gain_root(N);
  localparam logic [63:0] START_X = ((64'd1 << 60) + GAIN_A / 2) / GAIN_A;

  pipe_ctrl_t ctrl;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;
  xy_t sx, cx, sy, cy, sz, cz;
  logic signed [15:0] r [9];

  // The pipeline advances unless a finished result is waiting.
  assign ctrl.en     = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = ctrl.en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.en) begin
      vld_r <= vld_nxt;
    end
  end

  // One CORDIC lane per angle.
  ea2r_cordic_lane #(.STAGES(N), .START_X(START_X)) u_lane_x (
    .clk(clk), .ctrl(ctrl), .angle(in_ch.angle_x), .sin_o(sx), .cos_o(cx));
  ea2r_cordic_lane #(.STAGES(N), .START_X(START_X)) u_lane_y (
    .clk(clk), .ctrl(ctrl), .angle(in_ch.angle_y), .sin_o(sy), .cos_o(cy));
  ea2r_cordic_lane #(.STAGES(N), .START_X(START_X)) u_lane_z (
    .clk(clk), .ctrl(ctrl), .angle(in_ch.angle_z), .sin_o(sz), .cos_o(cz));

  ea2r_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk(clk), .ctrl(ctrl), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz), .r_o(r));

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.r00 = r[0];
  assign out_ch.r01 = r[1];
  assign out_ch.r02 = r[2];
  assign out_ch.r10 = r[3];
  assign out_ch.r11 = r[4];
  assign out_ch.r12 = r[5];
  assign out_ch.r20 = r[6];
  assign out_ch.r21 = r[7];
  assign out_ch.r22 = r[8];

`ifndef SYNTH
  // A stalled pipeline keeps its valid pattern.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.en |=> $stable(vld_r)) else $error("valid pipeline moved during a stall");
  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("result pending after reset");
  // Element r11 stays within plus or minus one when the format fits the port.
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && OUT_FRAC_BITS <= 14) |->
      ($signed(out_ch.r11) <= 17'sd16384 && $signed(out_ch.r11) >= -17'sd16384))
    else $error("matrix element out of range");
`endif

endmodule
